### design/aasfc_pkg.sv
`timescale 1ns / 1ps
package aasfc_pkg;

    // Register map
    localparam logic [1:0] REG_MUTE_SECONDS    = 2'd0;
    localparam logic [1:0] REG_STANDBY_SECONDS = 2'd1;
    localparam logic [1:0] REG_POWERUP_MS      = 2'd2;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [9:0]  RST_MUTE_SECONDS    = 10'd60;
    localparam logic [9:0]  RST_STANDBY_SECONDS = 10'd300;
    localparam logic [15:0] RST_POWERUP_MS      = 16'd3000;

    localparam int unsigned DEF_TICKS_PER_SECOND = 1000;
    localparam int unsigned DEF_ADC_LEVELS       = 1024;

    localparam int unsigned COUNT_W = 20;

    // Fan curve: T = (6600*code - 800*A) / (39*A), duty ramps from T=40 to T=80
    localparam int unsigned FAN_GAIN   = 6600;
    localparam int unsigned FAN_OFFSET = 800;
    localparam int unsigned FAN_DIV    = 39;
    localparam int unsigned FAN_T_START = 40;
    localparam int unsigned FAN_T_FULL  = 80;
    localparam logic [8:0]  FAN_DUTY_MIN = 9'd64;
    localparam logic [8:0]  FAN_DUTY_MAX = 9'd256;
    localparam logic [8:0]  FAN_DUTY_OFF = 9'd0;

    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_POWERUP = 2'd1,
        MODE_ON      = 2'd2,
        MODE_MUTED   = 2'd3
    } mode_t;

    typedef struct packed {
        logic load;    // take the tick, update mode and counters
        logic mul;     // latch the fan-curve quotient
        logic finish;  // form fan duty and output beat
    } cmd_t;

endpackage

### design/aasfc_ctrl.sv
`timescale 1ns / 1ps
module aasfc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output aasfc_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_SEND);

    assign cmd.load   = (state_reg == ST_IDLE) && s_axis_tvalid;
    assign cmd.mul    = (state_reg == ST_MUL);
    assign cmd.finish = (state_reg == ST_FIN);

endmodule

### design/aasfc_dp.sv
`timescale 1ns / 1ps
module aasfc_dp #(
    parameter int unsigned TICKS_PER_SECOND = aasfc_pkg::DEF_TICKS_PER_SECOND,
    parameter int unsigned ADC_LEVELS       = aasfc_pkg::DEF_ADC_LEVELS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aasfc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [aasfc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [15:0]                         in_data,
    input  aasfc_pkg::cmd_t                     cmd,
    output logic [15:0]                         out_data
);

    localparam int unsigned CW = aasfc_pkg::COUNT_W;
    localparam logic [CW-1:0] TPS = CW'(TICKS_PER_SECOND);

    // Fan curve constants, scaled by the ADC range
    localparam int unsigned DEN_I  = aasfc_pkg::FAN_DIV * ADC_LEVELS;
    localparam logic [24:0] OFF    = 25'(aasfc_pkg::FAN_OFFSET * ADC_LEVELS
                                         + aasfc_pkg::FAN_T_START * DEN_I);
    localparam logic [24:0] FULL   = 25'(aasfc_pkg::FAN_OFFSET * ADC_LEVELS
                                         + aasfc_pkg::FAN_T_FULL * DEN_I);
    localparam logic [24:0] GAIN   = 25'(aasfc_pkg::FAN_GAIN);

    // Reciprocal of DEN, rounded up, scaled by 2^Q_SHIFT
    localparam int unsigned     Q_SHIFT = 40;
    localparam longint unsigned RECIP_L = ((64'd1 << Q_SHIFT) + 64'(DEN_I) - 64'd1)
                                          / 64'(DEN_I);
    localparam logic [26:0]     RECIP   = 27'(RECIP_L);

    // Configuration
    logic [9:0]  mute_sec_reg;
    logic [9:0]  stby_sec_reg;
    logic [15:0] pwrup_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_sec_reg <= aasfc_pkg::RST_MUTE_SECONDS;
            stby_sec_reg <= aasfc_pkg::RST_STANDBY_SECONDS;
            pwrup_ms_reg <= aasfc_pkg::RST_POWERUP_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                aasfc_pkg::REG_MUTE_SECONDS:    mute_sec_reg <= cfg_data[9:0];
                aasfc_pkg::REG_STANDBY_SECONDS: stby_sec_reg <= cfg_data[9:0];
                aasfc_pkg::REG_POWERUP_MS:      pwrup_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Tick fields
    logic       audio_level;
    logic       audio_change;
    logic       button_press;
    logic       user_activity;
    logic [9:0] temp_sample;

    assign audio_level   = in_data[0];
    assign audio_change  = in_data[1];
    assign button_press  = in_data[2];
    assign user_activity = in_data[3];
    assign temp_sample   = in_data[13:4];

    // Mode and countdowns
    aasfc_pkg::mode_t mode_reg, mode_next;
    logic [CW-1:0] mute_left_reg, mute_left_next;
    logic [CW-1:0] stby_left_reg, stby_left_next;
    logic [15:0]   pwrup_left_reg, pwrup_left_next;

    logic [CW-1:0] mute_full;
    logic [CW-1:0] stby_full;

    assign mute_full = CW'(mute_sec_reg * TPS);
    assign stby_full = CW'(stby_sec_reg * TPS);

    always_comb
    begin
        aasfc_pkg::mode_t m;
        aasfc_pkg::mode_t target;
        logic [CW-1:0]    ml;
        logic [CW-1:0]    sl;
        logic [15:0]      pl;

        m      = mode_reg;
        ml     = mute_left_reg;
        sl     = stby_left_reg;
        pl     = pwrup_left_reg;
        target = aasfc_pkg::MODE_ON;

        if (audio_change)
        begin
            ml = mute_full;
            sl = stby_full;
        end
        if (button_press)
        begin
            if (m == aasfc_pkg::MODE_STANDBY || m == aasfc_pkg::MODE_MUTED)
            begin
                ml = mute_full;
                sl = stby_full;
            end
            else
            begin
                ml = '0;
                sl = '0;
            end
        end

        if (ml != '0)
        begin
            ml     = ml - 1'b1;
            target = aasfc_pkg::MODE_ON;
        end
        else
        begin
            target = aasfc_pkg::MODE_MUTED;
        end
        if (sl != '0)
            sl = sl - 1'b1;
        else
            target = aasfc_pkg::MODE_STANDBY;

        if (audio_level)
        begin
            ml     = mute_full;
            sl     = stby_full;
            target = aasfc_pkg::MODE_ON;
        end

        if (m == aasfc_pkg::MODE_POWERUP)
        begin
            if (pl != '0)
                pl = pl - 1'b1;
            if (pl == '0)
                m = aasfc_pkg::MODE_ON;
        end
        else if (target == aasfc_pkg::MODE_STANDBY)
        begin
            m = aasfc_pkg::MODE_STANDBY;
        end
        else if (target == aasfc_pkg::MODE_MUTED)
        begin
            if (m == aasfc_pkg::MODE_ON)
                m = aasfc_pkg::MODE_MUTED;
        end
        else
        begin
            if (m == aasfc_pkg::MODE_MUTED)
            begin
                m = aasfc_pkg::MODE_ON;
            end
            else if (m == aasfc_pkg::MODE_STANDBY)
            begin
                m  = aasfc_pkg::MODE_POWERUP;
                pl = pwrup_ms_reg;
            end
        end

        if (user_activity && m != aasfc_pkg::MODE_STANDBY)
        begin
            ml = mute_full;
            sl = stby_full;
        end

        mode_next       = m;
        mute_left_next  = ml;
        stby_left_next  = sl;
        pwrup_left_next = pl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= aasfc_pkg::MODE_STANDBY;
            mute_left_reg  <= CW'(aasfc_pkg::RST_MUTE_SECONDS * TPS);
            stby_left_reg  <= CW'(aasfc_pkg::RST_STANDBY_SECONDS * TPS);
            pwrup_left_reg <= '0;
        end
        else if (cmd.load)
        begin
            mode_reg       <= mode_next;
            mute_left_reg  <= mute_left_next;
            stby_left_reg  <= stby_left_next;
            pwrup_left_reg <= pwrup_left_next;
        end
    end

    // Fan curve: range check at load, quotient by reciprocal multiply next cycle.
    // floor(rem*RECIP / 2^Q_SHIFT) equals floor(rem/DEN) for rem below 40*DEN:
    // the rounding error of RECIP times rem stays under 2^Q_SHIFT.
    logic [24:0] prod;
    logic [22:0] rem_reg;
    logic [49:0] q_prod;
    logic [5:0]  quot_reg;
    logic        lo_reg;
    logic        hi_reg;

    assign prod   = 25'(temp_sample) * GAIN;
    assign q_prod = 50'(rem_reg) * 50'(RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg  <= (prod < OFF);
            hi_reg  <= (prod >= FULL);
            rem_reg <= 23'(prod - OFF);
        end
        if (cmd.mul)
        begin
            quot_reg <= q_prod[Q_SHIFT+5:Q_SHIFT];
        end
    end

    // duty = 64 + floor(q*24/5); x/5 as (x*205)>>10, exact for x up to 960
    logic [9:0]  ramp_x;
    logic [17:0] ramp_y;
    logic [8:0]  duty;
    logic        amp_active;

    assign ramp_x = 10'(quot_reg * 10'd24);
    assign ramp_y = 18'(ramp_x * 18'd205);
    assign amp_active = (mode_reg == aasfc_pkg::MODE_ON) || (mode_reg == aasfc_pkg::MODE_MUTED);

    always_comb
    begin
        if (!amp_active || lo_reg)
            duty = aasfc_pkg::FAN_DUTY_OFF;
        else if (hi_reg)
            duty = aasfc_pkg::FAN_DUTY_MAX;
        else
            duty = aasfc_pkg::FAN_DUTY_MIN + 9'(ramp_y[17:10]);
    end

    logic [15:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg <= {1'b0,
                        duty,
                        amp_active,
                        (mode_reg == aasfc_pkg::MODE_ON),
                        amp_active,
                        (mode_reg != aasfc_pkg::MODE_STANDBY),
                        mode_reg};
        end
    end

    assign out_data = out_reg;

endmodule

### design/amp_auto_standby_and_fan_controller.sv
`timescale 1ns / 1ps
// After an input beat is accepted (load), the sequencer steps through the fan
// quotient multiply and the output latch, then holds the output beat valid until
// the result is taken; the next tick is taken only once the result is taken.
// Reset (rst_n, async, active low): standby mode, countdowns at the reset
// register values, no output beat pending.
module amp_auto_standby_and_fan_controller #(
    parameter int unsigned TICKS_PER_SECOND = aasfc_pkg::DEF_TICKS_PER_SECOND,
    parameter int unsigned ADC_LEVELS       = aasfc_pkg::DEF_ADC_LEVELS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Register write: 0 mute_seconds, 1 standby_seconds, 2 powerup_ms
    input  logic                              cfg_we,
    input  logic [aasfc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [aasfc_pkg::CFG_DATA_W-1:0]  cfg_data,

    // One beat per 1 ms tick
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] audio_level, [1] audio_change, [2] button_press, [3] user_activity,
    // [13:4] temp_sample, [15:14] zero
    input  logic [15:0]                       s_axis_tdata,

    // One result beat per tick
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] mode, [2] supply_enable, [3] amp_run, [4] amp_unmute,
    // [5] speaker_connect, [14:6] fan_duty, [15] zero
    output logic [15:0]                       m_axis_tdata
);

    // Sequencer commands to the datapath: load the tick, latch the fan
    // quotient, then latch the output beat.
    aasfc_pkg::cmd_t cmd;

    aasfc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    // Mode machine, countdowns and fan curve arithmetic.
    aasfc_dp #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .ADC_LEVELS       (ADC_LEVELS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_data  (s_axis_tdata),
        .cmd      (cmd),
        .out_data (m_axis_tdata)
    );

endmodule
